@@ rtl/sls16_pkg.sv @@
// ----------------------------------------------------------------------------
// sls16_pkg
// Shared types, command codes and helpers for the 16-channel serial
// low-side switch.
// ----------------------------------------------------------------------------
package sls16_pkg;

  // Command nibble, frame bits [15:12]
  typedef enum logic [3:0] {
    CMD_DIAG     = 4'h0,
    CMD_OR       = 4'h3,
    CMD_SDIAG    = 4'hC,
    CMD_LOOPBACK = 4'hA,
    CMD_AND      = 4'hF
  } cmd_t;

  // Half select nibble, frame bits [11:8]
  localparam logic [3:0] HALF_LO = 4'h0;
  localparam logic [3:0] HALF_HI = 4'hF;

  localparam logic [1:0] LOAD_OK = 2'b11;

  // One word as held in the input register
  typedef struct packed {
    logic [15:0] spi_frame;
    logic [7:0]  parallel_in;
    logic [31:0] load_status;
  } word_t;

  // Bit k set when channel k of the half reports ok
  function automatic logic [7:0] short_diag(input logic [15:0] diag);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[k] = (diag[2*k +: 2] == LOAD_OK);
    end
    return r;
  endfunction

endpackage

@@ rtl/spi_low_side_switch_16ch_unit.sv @@
// ----------------------------------------------------------------------------
// spi_low_side_switch_16ch_unit
// Chip side of a 16-bit serial link to a 16-channel low-side switch.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input register, and its result in the
// output register, where out_valid is raised (input reg, output reg).
// Throughput: one word per cycle; with the output stalled two words are held
// and in_ready drops until out_ready returns.
// The decode and state update is a single combinational pass in the core.
// Reset (rst_n low, synchronous): serial switch bits cleared, OR mode in both halves,
// pending reply zero, echo disarmed, both registers empty.
module spi_low_side_switch_16ch_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_spi_frame,
  input  logic [7:0]  in_parallel_in,
  input  logic [31:0] in_load_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_spi_reply,
  output logic [15:0] out_switch_on
);
  import sls16_pkg::*;

  logic        word_valid;
  word_t       word;
  logic        advance;
  logic [15:0] reply;
  logic [15:0] switch_on;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] spi_reply_r;
  logic [15:0] switch_on_r;

  assign advance = word_valid && (!out_valid_r || out_ready);

  sls16_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_spi_frame   (in_spi_frame),
    .in_parallel_in (in_parallel_in),
    .in_load_status (in_load_status),
    .advance        (advance),
    .word_valid     (word_valid),
    .word           (word)
  );

  sls16_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .word      (word),
    .reply     (reply),
    .switch_on (switch_on)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      spi_reply_r <= reply;
      switch_on_r <= switch_on;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_spi_reply = spi_reply_r;
  assign out_switch_on = switch_on_r;

endmodule

@@ rtl/sls16_in_reg.sv @@
// ----------------------------------------------------------------------------
// sls16_in_reg
// Input register: captures one word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module sls16_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_spi_frame,
  input  logic [7:0]          in_parallel_in,
  input  logic [31:0]         in_load_status,
  input  logic                advance,
  output logic                word_valid,
  output sls16_pkg::word_t    word
);
  import sls16_pkg::*;

  logic  valid_r, valid_nxt;
  word_t word_r;

  // Refill in the same cycle the held word moves on
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r.spi_frame   <= in_spi_frame;
      word_r.parallel_in <= in_parallel_in;
      word_r.load_status <= in_load_status;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

@@ rtl/sls16_core.sv @@
// ----------------------------------------------------------------------------
// sls16_core
// Frame decode, switch state and reply preparation. State updates when a
// word advances to the output register.
// ----------------------------------------------------------------------------
module sls16_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  sls16_pkg::word_t word,
  output logic [15:0]      reply,
  output logic [15:0]      switch_on
);
  import sls16_pkg::*;

  logic [15:0] serial_bits_r, serial_bits_nxt;
  logic [1:0]  and_mode_r, and_mode_nxt;
  logic [15:0] reply_next_r, reply_next_nxt;
  logic        echo_armed_r, echo_armed_nxt;

  logic [3:0]  sel;
  logic        sel_ok;
  logic        half;
  logic [7:0]  data;
  logic [15:0] half_diag;

  assign sel       = word.spi_frame[11:8];
  assign sel_ok    = (sel == HALF_LO) || (sel == HALF_HI);
  assign half      = (sel == HALF_HI);
  assign data      = word.spi_frame[7:0];
  assign half_diag = half ? word.load_status[31:16] : word.load_status[15:0];

  always_comb begin
    serial_bits_nxt = serial_bits_r;
    and_mode_nxt    = and_mode_r;
    reply_next_nxt  = reply_next_r;
    echo_armed_nxt  = echo_armed_r;
    reply           = reply_next_r;
    if (echo_armed_r) begin
      // Echo pass: frame returns as its own reply, no decode
      reply          = word.spi_frame;
      echo_armed_nxt = 1'b0;
      reply_next_nxt = '0;
    end else if (sel_ok) begin
      unique case (cmd_t'(word.spi_frame[15:12]))
        CMD_DIAG: begin
          reply_next_nxt = half_diag;
        end
        CMD_OR, CMD_AND: begin
          if (half) begin
            serial_bits_nxt[15:8] = data;
          end else begin
            serial_bits_nxt[7:0] = data;
          end
          and_mode_nxt[half] = (word.spi_frame[15:12] == CMD_AND);
          reply_next_nxt     = half_diag;
        end
        CMD_SDIAG: begin
          reply_next_nxt = {word.parallel_in, short_diag(half_diag)};
        end
        CMD_LOOPBACK: begin
          echo_armed_nxt = 1'b1;
          reply_next_nxt = '0;
        end
        default: begin
          // unknown command: drop
        end
      endcase
    end
  end

  // Drive from updated state and this word's pins
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      if (and_mode_nxt[h]) begin
        switch_on[8*h +: 4] = serial_bits_nxt[8*h +: 4] & word.parallel_in[4*h +: 4];
      end else begin
        switch_on[8*h +: 4] = serial_bits_nxt[8*h +: 4] | word.parallel_in[4*h +: 4];
      end
      switch_on[8*h+4 +: 4] = serial_bits_nxt[8*h+4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_bits_r <= '0;
      and_mode_r    <= '0;
      reply_next_r  <= '0;
      echo_armed_r  <= 1'b0;
    end else if (advance) begin
      serial_bits_r <= serial_bits_nxt;
      and_mode_r    <= and_mode_nxt;
      reply_next_r  <= reply_next_nxt;
      echo_armed_r  <= echo_armed_nxt;
    end
  end

  a_echo_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && echo_armed_r |=> !echo_armed_r && (reply_next_r == '0))
    else $error("echo pass did not clear echo state");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(serial_bits_r) && $stable(and_mode_r)
                 && $stable(reply_next_r) && $stable(echo_armed_r))
    else $error("state changed without a word");

  a_bad_half_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !echo_armed_r && !sel_ok |=> $stable(serial_bits_r)
      && $stable(and_mode_r) && $stable(reply_next_r) && !echo_armed_r)
    else $error("bad half select changed state");

  a_and_mode_mask: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !and_mode_nxt[0] |->
      ((switch_on[3:0] & serial_bits_nxt[3:0]) == serial_bits_nxt[3:0]))
    else $error("OR mode channel off while serial bit set");

endmodule
